// ===== hdl/lasu_pkg.sv =====
// ----------------------------------------------------------------------------
// lasu_pkg
// Shared types and constants of the local alignment scorer: field widths,
// score limits, configuration register indexes and the chain control word.
// ----------------------------------------------------------------------------
package lasu_pkg;

  localparam int SYM_W      = 8;
  localparam int WGT_W      = 8;
  localparam int SCORE_W    = 15;
  localparam int ROW_OUT_W  = 16;
  localparam int COL_OUT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_MAX_REF_LEN   = 256;
  localparam int DEF_MAX_QUERY_LEN = 65535;

  localparam logic [SCORE_W-1:0] SCORE_CAP = '1;

  localparam logic signed [WGT_W-1:0] MATCH_RST    = 8'sd1;
  localparam logic signed [WGT_W-1:0] MISMATCH_RST = -8'sd1;
  localparam logic signed [WGT_W-1:0] GAP_RST      = -8'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP      = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Control word that rides along the cell chain with each item
  typedef struct packed {
    logic valid;
    logic query;    // query row, else reference byte
    logic first;    // first row of a query: column scores start at zero
    logic last;     // last row of a query: result is due
    logic new_ref;  // reference byte that opens a new reference
    logic wr;       // reference byte is stored (length not saturated)
  } lasu_ctrl_t;

endpackage

// ===== hdl/lasu_if.sv =====
// ----------------------------------------------------------------------------
// lasu_in_if / lasu_out_if
// Valid/ready channels of the local alignment scorer: sequence bytes in,
// alignment results out.
// ----------------------------------------------------------------------------
interface lasu_in_if;
  import lasu_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output op, output symbol, output last, input ready);
  modport sink   (input valid, input op, input symbol, input last, output ready);
endinterface

interface lasu_out_if;
  import lasu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SCORE_W-1:0]   best_score;
  logic [ROW_OUT_W-1:0] end_row;
  logic [COL_OUT_W-1:0] end_col;

  modport source (output valid, output best_score, output end_row, output end_col,
                  input ready);
  modport sink   (input valid, input best_score, input end_row, input end_col,
                  output ready);
endinterface

// ===== hdl/lasu_cell.sv =====
// ----------------------------------------------------------------------------
// lasu_cell
// One column of the score matrix: holds a reference byte and the column's
// last score, computes one cell per query row and passes the row on.
// ----------------------------------------------------------------------------
module lasu_cell #(
  parameter int COL = 1,
  parameter int AW  = 8,
  parameter int CW  = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic signed [lasu_pkg::WGT_W-1:0]   match_score,
  input  logic signed [lasu_pkg::WGT_W-1:0]   mismatch_score,
  input  logic signed [lasu_pkg::WGT_W-1:0]   gap_score,
  input  lasu_pkg::lasu_ctrl_t                i_ctrl,
  input  logic [lasu_pkg::SYM_W-1:0]          i_sym,
  input  logic [AW-1:0]                       i_addr,
  input  logic [lasu_pkg::SCORE_W-1:0]        i_left,
  input  logic [lasu_pkg::SCORE_W-1:0]        i_diag,
  input  logic [lasu_pkg::SCORE_W-1:0]        i_rb_score,
  input  logic [CW-1:0]                       i_rb_col,
  output lasu_pkg::lasu_ctrl_t                o_ctrl,
  output logic [lasu_pkg::SYM_W-1:0]          o_sym,
  output logic [AW-1:0]                       o_addr,
  output logic [lasu_pkg::SCORE_W-1:0]        o_left,
  output logic [lasu_pkg::SCORE_W-1:0]        o_diag,
  output logic [lasu_pkg::SCORE_W-1:0]        o_rb_score,
  output logic [CW-1:0]                       o_rb_col
);
  import lasu_pkg::*;

  localparam int SW = SCORE_W + 2;

  logic                 active_r, active_nxt;
  logic [SYM_W-1:0]     ref_r, ref_nxt;
  logic [SCORE_W-1:0]   h_r, h_nxt;

  lasu_ctrl_t           ctrl_r;
  logic [SYM_W-1:0]     sym_r;
  logic [AW-1:0]        addr_r;
  logic [SCORE_W-1:0]   left_r, left_nxt;
  logic [SCORE_W-1:0]   diag_r, diag_nxt;
  logic [SCORE_W-1:0]   rbs_r, rbs_nxt;
  logic [CW-1:0]        rbc_r, rbc_nxt;

  logic [SCORE_W-1:0]   up;
  logic [WGT_W-1:0]     sub;
  logic signed [SW-1:0] d_sum, u_sum, l_sum, mx;
  logic [SCORE_W-1:0]   cell_v;

  always_comb begin
    up  = i_ctrl.first ? '0 : h_r;
    sub = (ref_r == i_sym) ? match_score : mismatch_score;

    d_sum = $signed({2'b00, i_diag}) + $signed({{(SW-WGT_W){sub[WGT_W-1]}}, sub});
    u_sum = $signed({2'b00, up}) + $signed({{(SW-WGT_W){gap_score[WGT_W-1]}}, gap_score});
    l_sum = $signed({2'b00, i_left}) + $signed({{(SW-WGT_W){gap_score[WGT_W-1]}}, gap_score});

    mx = d_sum;
    if (u_sum > mx) mx = u_sum;
    if (l_sum > mx) mx = l_sum;

    // floor at zero, saturate at the score cap
    if (mx < 0) begin
      cell_v = '0;
    end else if (mx > $signed({2'b00, SCORE_CAP})) begin
      cell_v = SCORE_CAP;
    end else begin
      cell_v = mx[SCORE_W-1:0];
    end
  end

  always_comb begin
    active_nxt = active_r;
    ref_nxt    = ref_r;
    h_nxt      = h_r;
    left_nxt   = cell_v;
    diag_nxt   = up;
    rbs_nxt    = i_rb_score;
    rbc_nxt    = i_rb_col;
    if (i_ctrl.valid && i_ctrl.query) begin
      h_nxt = cell_v;
      // keep the first column of the row maximum
      if (active_r && (cell_v > i_rb_score)) begin
        rbs_nxt = cell_v;
        rbc_nxt = CW'(COL);
      end
    end else if (i_ctrl.valid) begin
      if (i_ctrl.new_ref) active_nxt = 1'b0;
      if (i_ctrl.wr && (i_addr == AW'(COL - 1))) begin
        active_nxt = 1'b1;
        ref_nxt    = i_sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ctrl_r   <= '0;
    end else if (en) begin
      active_r <= active_nxt;
      ctrl_r   <= i_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ref_r  <= ref_nxt;
      h_r    <= h_nxt;
      sym_r  <= i_sym;
      addr_r <= i_addr;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      rbs_r  <= rbs_nxt;
      rbc_r  <= rbc_nxt;
    end
  end

  assign o_ctrl     = ctrl_r;
  assign o_sym      = sym_r;
  assign o_addr     = addr_r;
  assign o_left     = left_r;
  assign o_diag     = diag_r;
  assign o_rb_score = rbs_r;
  assign o_rb_col   = rbc_r;

endmodule

// ===== hdl/lasu_collect.sv =====
// ----------------------------------------------------------------------------
// lasu_collect
// End of the cell chain: merges each row maximum into the running best,
// counts rows and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module lasu_collect #(
  parameter int MAX_QUERY_LEN = lasu_pkg::DEF_MAX_QUERY_LEN,
  parameter int CW            = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lasu_pkg::lasu_ctrl_t             i_ctrl,
  input  logic [lasu_pkg::SCORE_W-1:0]     i_rb_score,
  input  logic [CW-1:0]                    i_rb_col,
  input  logic                             out_ready,
  output logic                             adv,
  output logic                             out_valid,
  output logic [lasu_pkg::SCORE_W-1:0]     best_score,
  output logic [lasu_pkg::ROW_OUT_W-1:0]   end_row,
  output logic [lasu_pkg::COL_OUT_W-1:0]   end_col
);
  import lasu_pkg::*;

  localparam int RW = $clog2(MAX_QUERY_LEN + 1);

  logic [RW-1:0]        row_r, row_nxt;
  logic [SCORE_W-1:0]   top_r, top_nxt;
  logic [ROW_OUT_W-1:0] trow_r, trow_nxt;
  logic [COL_OUT_W-1:0] tcol_r, tcol_nxt;
  logic                 ov_r, ov_nxt;
  logic [SCORE_W-1:0]   os_r;
  logic [ROW_OUT_W-1:0] orow_r;
  logic [COL_OUT_W-1:0] ocol_r;
  logic                 take;
  logic                 emit;

  // freeze the chain only when a result is due and the last one is not taken
  assign adv  = !(ov_r && !out_ready && i_ctrl.valid && i_ctrl.query && i_ctrl.last);
  assign take = adv && i_ctrl.valid && i_ctrl.query;
  assign emit = take && i_ctrl.last;

  always_comb begin
    row_nxt  = row_r;
    top_nxt  = top_r;
    trow_nxt = trow_r;
    tcol_nxt = tcol_r;
    if (take) begin
      if (i_ctrl.first) begin
        row_nxt  = RW'(1);
        top_nxt  = '0;
        trow_nxt = '0;
        tcol_nxt = '0;
      end else if (row_r < RW'(MAX_QUERY_LEN)) begin
        row_nxt = row_r + RW'(1);
      end
      if (i_rb_score > top_nxt) begin
        top_nxt  = i_rb_score;
        trow_nxt = ROW_OUT_W'(row_nxt);
        tcol_nxt = COL_OUT_W'(i_rb_col);
      end
    end
    ov_nxt = (ov_r && !out_ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      row_r  <= '0;
      top_r  <= '0;
      trow_r <= '0;
      tcol_r <= '0;
    end else begin
      ov_r   <= ov_nxt;
      row_r  <= row_nxt;
      top_r  <= top_nxt;
      trow_r <= trow_nxt;
      tcol_r <= tcol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      os_r   <= top_nxt;
      orow_r <= trow_nxt;
      ocol_r <= tcol_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign best_score = os_r;
  assign end_row    = orow_r;
  assign end_col    = ocol_r;

endmodule

// ===== hdl/local_alignment_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// local_alignment_scorer_unit
// Smith-Waterman local alignment score, linear gap, on a systolic cell row.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries bytes: op = 0 loads one reference byte, last = 1 closes the
//   reference; op = 1 streams one query byte, last = 1 closes the query.
//   out_ch carries one result per query: best score and its first end
//   position (1-based row and column, zero when the score is zero).
//   cfg_we/cfg_index/cfg_data write match, mismatch and gap scores; write
//   them only while no item is in flight.
// Throughput: one byte per cycle, reference or query, while the chain is not
//   frozen. Every byte walks down a chain of MAX_REF_LEN cells, one per
//   reference column; each cell does one matrix cell of a query row per cycle.
// Output: out_ch.valid rises once the last query byte has passed the entry
//   stage register, the MAX_REF_LEN cells and the result register.
// Reset: reference length zero, no query open, scores 1 / -1 / -1, chain
//   empty.
// Stall: the chain freezes only when a query end reaches the chain tail while
//   the previous result still waits; in_ch.ready drops for those cycles.
// ----------------------------------------------------------------------------
module local_alignment_scorer_unit #(
  parameter int MAX_REF_LEN   = lasu_pkg::DEF_MAX_REF_LEN,
  parameter int MAX_QUERY_LEN = lasu_pkg::DEF_MAX_QUERY_LEN
) (
  input  logic                                clk,
  input  logic                                rst_n,
  lasu_in_if.sink                             in_ch,
  lasu_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [lasu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lasu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lasu_pkg::*;

  localparam int N  = MAX_REF_LEN;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int LW = $clog2(N + 1);
  localparam int CW = $clog2(N + 1);

  // configuration
  logic signed [WGT_W-1:0] match_r, mismatch_r, gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= MATCH_RST;
      mismatch_r <= MISMATCH_RST;
      gap_r      <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH:    match_r    <= cfg_data;
        REG_MISMATCH: mismatch_r <= cfg_data;
        REG_GAP:      gap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: turn each byte into a chain token
  logic            adv;
  logic            accept;
  logic            ref_open_r, ref_open_nxt;
  logic            q_open_r, q_open_nxt;
  logic [LW-1:0]   ref_len_r, ref_len_nxt;
  logic [LW-1:0]   wr_idx;
  lasu_ctrl_t      tok;

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  always_comb begin
    tok          = '0;
    tok.valid    = 1'b1;
    wr_idx       = ref_open_r ? ref_len_r : '0;
    ref_open_nxt = ref_open_r;
    q_open_nxt   = q_open_r;
    ref_len_nxt  = ref_len_r;
    if (in_ch.op == OP_QUERY) begin
      tok.query = 1'b1;
      tok.first = !q_open_r;
      tok.last  = in_ch.last;
      if (accept) q_open_nxt = !in_ch.last;
    end else begin
      tok.new_ref = !ref_open_r;
      tok.wr      = (wr_idx < LW'(N));
      if (accept) begin
        q_open_nxt   = 1'b0;
        ref_open_nxt = !in_ch.last;
        ref_len_nxt  = tok.wr ? (wr_idx + LW'(1)) : wr_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_open_r <= 1'b0;
      q_open_r   <= 1'b0;
      ref_len_r  <= '0;
    end else begin
      ref_open_r <= ref_open_nxt;
      q_open_r   <= q_open_nxt;
      ref_len_r  <= ref_len_nxt;
    end
  end

  // chain entry stage
  lasu_ctrl_t       s0_ctrl_r;
  logic [SYM_W-1:0] s0_sym_r;
  logic [AW-1:0]    s0_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctrl_r <= '0;
    end else if (adv) begin
      s0_ctrl_r <= accept ? tok : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sym_r  <= in_ch.symbol;
      s0_addr_r <= wr_idx[AW-1:0];
    end
  end

  // cell chain
  lasu_ctrl_t         ch_ctrl [0:N];
  logic [SYM_W-1:0]   ch_sym  [0:N];
  logic [AW-1:0]      ch_addr [0:N];
  logic [SCORE_W-1:0] ch_left [0:N];
  logic [SCORE_W-1:0] ch_diag [0:N];
  logic [SCORE_W-1:0] ch_rbs  [0:N];
  logic [CW-1:0]      ch_rbc  [0:N];

  assign ch_ctrl[0] = s0_ctrl_r;
  assign ch_sym[0]  = s0_sym_r;
  assign ch_addr[0] = s0_addr_r;
  assign ch_left[0] = '0;
  assign ch_diag[0] = '0;
  assign ch_rbs[0]  = '0;
  assign ch_rbc[0]  = '0;

  for (genvar g = 1; g <= N; g++) begin : g_cell
    lasu_cell #(
      .COL (g),
      .AW  (AW),
      .CW  (CW)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (adv),
      .match_score    (match_r),
      .mismatch_score (mismatch_r),
      .gap_score      (gap_r),
      .i_ctrl         (ch_ctrl[g-1]),
      .i_sym          (ch_sym[g-1]),
      .i_addr         (ch_addr[g-1]),
      .i_left         (ch_left[g-1]),
      .i_diag         (ch_diag[g-1]),
      .i_rb_score     (ch_rbs[g-1]),
      .i_rb_col       (ch_rbc[g-1]),
      .o_ctrl         (ch_ctrl[g]),
      .o_sym          (ch_sym[g]),
      .o_addr         (ch_addr[g]),
      .o_left         (ch_left[g]),
      .o_diag         (ch_diag[g]),
      .o_rb_score     (ch_rbs[g]),
      .o_rb_col       (ch_rbc[g])
    );
  end

  lasu_collect #(
    .MAX_QUERY_LEN (MAX_QUERY_LEN),
    .CW            (CW)
  ) u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .i_ctrl     (ch_ctrl[N]),
    .i_rb_score (ch_rbs[N]),
    .i_rb_col   (ch_rbc[N]),
    .out_ready  (out_ch.ready),
    .adv        (adv),
    .out_valid  (out_ch.valid),
    .best_score (out_ch.best_score),
    .end_row    (out_ch.end_row),
    .end_col    (out_ch.end_col)
  );

endmodule

// ===== hdl/lasu_checker.sv =====
// ----------------------------------------------------------------------------
// lasu_checker
// Port-level checks of the local alignment scorer, bound to the top level.
// ----------------------------------------------------------------------------
module lasu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [lasu_pkg::SCORE_W-1:0]     best_score,
  input logic [lasu_pkg::ROW_OUT_W-1:0]   end_row,
  input logic [lasu_pkg::COL_OUT_W-1:0]   end_col
);
  import lasu_pkg::*;

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(best_score) &&
                                $stable(end_row) && $stable(end_col))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a zero score has no end position
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (best_score == '0) |-> (end_row == '0) && (end_col == '0))
    else $error("zero score with nonzero position");

  // input only stalls behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind local_alignment_scorer_unit lasu_checker u_lasu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .best_score (out_ch.best_score),
  .end_row    (out_ch.end_row),
  .end_col    (out_ch.end_col)
);
